@@ rtl/tdpt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime test: shared package
// Widths, limits, sequencer states and the status bundle of the remainder unit.
// ----------------------------------------------------------------------------
package tdpt_pkg;

	// Bits of the candidate that take part in the test (4 to 16, the candidate field width).
	localparam int WIDTH = 16;

	// Fixed widths of the channel fields.
	localparam int CAND_W = 16;
	localparam int COUNT_W = 7;

	// Trial divisor width: the divisor runs up to floor(sqrt(n)) + 1.
	localparam int DIV_W = (WIDTH + 1) / 2 + 1;
	// Running square of the divisor, which may pass n by up to 2*sqrt(n) + 1.
	localparam int SQ_W = WIDTH + 2;
	// Internal divisor count, one bit wider than the field to see the limit.
	localparam int CNT_W = COUNT_W + 1;
	// Bit counter of the remainder unit.
	localparam int BIT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(127);
	localparam logic [CNT_W-1:0] PRIME_DIVISORS = CNT_W'(2);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_DONE
	} state_t;

	// Status of the remainder unit toward the sequencer.
	typedef struct packed {
		logic done;
		logic zero;
	} rem_stat_t;

endpackage

@@ rtl/tdpt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime test: channel interfaces
// Valid/ready channels for candidate beats and result beats.
// ----------------------------------------------------------------------------
interface tdpt_cand_if;
	logic                        valid;
	logic                        ready;
	logic [tdpt_pkg::CAND_W-1:0] candidate;

	modport source (output valid, output candidate, input ready);
	modport sink (input valid, input candidate, output ready);
endinterface

interface tdpt_res_if;
	logic                         valid;
	logic                         ready;
	logic                         is_prime;
	logic [tdpt_pkg::COUNT_W-1:0] divisor_count;

	modport source (output valid, output is_prime, output divisor_count, input ready);
	modport sink (input valid, input is_prime, input divisor_count, output ready);
endinterface

@@ rtl/tdpt_rem_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime test: remainder unit
// Restoring division, one quotient bit per cycle, reports n mod d == 0.
// ----------------------------------------------------------------------------
module tdpt_rem_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tdpt_pkg::WIDTH-1:0] n,
	input  logic [tdpt_pkg::DIV_W-1:0] d,
	output tdpt_pkg::rem_stat_t        stat
);

	logic                       busy_q;
	logic [tdpt_pkg::BIT_W-1:0] bit_q;
	logic [tdpt_pkg::WIDTH-1:0] num_q;
	logic [tdpt_pkg::DIV_W-1:0] rem_q;
	logic [tdpt_pkg::DIV_W:0]   trial;
	logic [tdpt_pkg::DIV_W:0]   diff;
	logic [tdpt_pkg::DIV_W-1:0] rem_next;

	// Bring down the next dividend bit and subtract the divisor when it fits.
	assign trial = {rem_q, num_q[tdpt_pkg::WIDTH-1]};
	assign diff = trial - {1'b0, d};
	assign rem_next = (trial >= {1'b0, d}) ? diff[tdpt_pkg::DIV_W-1:0]
	                                       : trial[tdpt_pkg::DIV_W-1:0];

	assign stat.done = busy_q && (bit_q == '0);
	assign stat.zero = (rem_next == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bit_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			bit_q <= tdpt_pkg::BIT_W'(tdpt_pkg::WIDTH - 1);
		end else if (busy_q) begin
			if (bit_q == '0) begin
				busy_q <= 1'b0;
			end
			bit_q <= bit_q - tdpt_pkg::BIT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= n;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[tdpt_pkg::WIDTH-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

endmodule

@@ rtl/trial_division_prime_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime test: top level
// Counts the divisors of a candidate and flags it prime when there are two.
// ----------------------------------------------------------------------------
// The block takes one candidate beat on the cand channel and, some time later,
// returns one result beat on the res channel carrying the divisor count and a
// prime flag. Only the low WIDTH bits of the candidate take part in the test.
// Divisors are found in pairs: each trial divisor d with d*d <= n is tested,
// and a hit adds two divisors, or one when d*d equals n. The count saturates
// at 127. A zero candidate reports a count of zero and one reports a count of
// one; neither is prime.
// Each trial passes through a check state and then the shared restoring
// remainder unit, whose bit loop sets the pace. After the result beat is
// taken the block goes back to idle before it accepts the next candidate.
// One item is in flight at a time: cand.ready is high only while the block is
// idle. A result beat stays on res, held stable, until the receiver takes it;
// the next candidate is taken only after that.
// Reset clears the sequencer to idle and drops res.valid; nothing else is kept
// from one item to the next.
// ----------------------------------------------------------------------------
module trial_division_prime_test (
	input  logic       clk,
	input  logic       arst_n,
	tdpt_cand_if.sink  cand,
	tdpt_res_if.source res
);

	tdpt_pkg::state_t           state_q;
	tdpt_pkg::state_t           state_d;
	logic [tdpt_pkg::WIDTH-1:0] n_q;
	logic [tdpt_pkg::DIV_W-1:0] d_q;
	logic [tdpt_pkg::SQ_W-1:0]  sq_q;
	logic [tdpt_pkg::CNT_W-1:0] cnt_q;
	logic [tdpt_pkg::CNT_W-1:0] cnt_add;
	logic                       rem_start;
	tdpt_pkg::rem_stat_t        rem_stat;
	logic                       sq_in_range;
	logic                       sq_exact;
	logic                       hit_limit;

	// The square of the trial divisor is kept alongside it, so the range test
	// is a single compare against the candidate.
	assign sq_in_range = (sq_q <= tdpt_pkg::SQ_W'(n_q));
	assign sq_exact = (sq_q == tdpt_pkg::SQ_W'(n_q));

	// A divisor below the square root pairs with its cofactor.
	assign cnt_add = cnt_q + (sq_exact ? tdpt_pkg::CNT_W'(1) : tdpt_pkg::CNT_W'(2));
	assign hit_limit = (cnt_add >= tdpt_pkg::COUNT_MAX);

	tdpt_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rem_start),
		.n      (n_q),
		.d      (d_q),
		.stat   (rem_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdpt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rem_start = 1'b0;
		cand.ready = 1'b0;
		res.valid = 1'b0;
		unique case (state_q)
			tdpt_pkg::ST_IDLE: begin
				cand.ready = 1'b1;
				if (cand.valid) begin
					state_d = tdpt_pkg::ST_CHECK;
				end
			end
			tdpt_pkg::ST_CHECK: begin
				if (sq_in_range) begin
					rem_start = 1'b1;
					state_d = tdpt_pkg::ST_DIV;
				end else begin
					state_d = tdpt_pkg::ST_DONE;
				end
			end
			tdpt_pkg::ST_DIV: begin
				if (rem_stat.done) begin
					if (rem_stat.zero && hit_limit) begin
						state_d = tdpt_pkg::ST_DONE;
					end else begin
						state_d = tdpt_pkg::ST_CHECK;
					end
				end
			end
			tdpt_pkg::ST_DONE: begin
				res.valid = 1'b1;
				if (res.ready) begin
					state_d = tdpt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tdpt_pkg::ST_IDLE;
			end
		endcase
	end

	// Working registers: candidate, trial divisor, its square and the count.
	always_ff @(posedge clk) begin
		if (cand.valid && cand.ready) begin
			n_q <= tdpt_pkg::WIDTH'(cand.candidate);
			d_q <= tdpt_pkg::DIV_W'(1);
			sq_q <= tdpt_pkg::SQ_W'(1);
			cnt_q <= '0;
		end else if (state_q == tdpt_pkg::ST_DIV && rem_stat.done) begin
			if (rem_stat.zero) begin
				cnt_q <= hit_limit ? tdpt_pkg::COUNT_MAX : cnt_add;
			end
			// (d + 1)^2 = d^2 + 2d + 1
			sq_q <= sq_q + tdpt_pkg::SQ_W'({d_q, 1'b1});
			d_q <= d_q + tdpt_pkg::DIV_W'(1);
		end
	end

	assign res.divisor_count = cnt_q[tdpt_pkg::COUNT_W-1:0];
	assign res.is_prime = (cnt_q == tdpt_pkg::PRIME_DIVISORS);

	// The block never offers a result while it is taking a candidate.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !cand.ready)
		else $error("result offered while taking a candidate");

	// A taken candidate starts its trials at divisor one with an empty count.
	a_start_trial: assert property (@(posedge clk) disable iff (!arst_n)
		(cand.valid && cand.ready) |=> (d_q == tdpt_pkg::DIV_W'(1) && cnt_q == '0
			&& state_q == tdpt_pkg::ST_CHECK))
		else $error("trial did not start from divisor one");

	// A division is only started with the divisor square still in range.
	a_div_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_start |-> (sq_in_range && d_q != '0))
		else $error("division started outside the divisor range");

	// The count never passes its saturation value.
	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != tdpt_pkg::ST_IDLE && $past(state_q) != tdpt_pkg::ST_IDLE)
		|-> (cnt_q <= tdpt_pkg::COUNT_MAX))
		else $error("divisor count beyond its limit");

	// A prime flag always comes with a count of two.
	a_prime_count: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.is_prime) |-> (res.divisor_count == tdpt_pkg::COUNT_W'(2)))
		else $error("prime flag without two divisors");

endmodule

@@ test/trial_division_prime_test_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime test: testbench
// Sends candidate beats and checks every result beat against a divisor tally.
// ----------------------------------------------------------------------------
// A directed set covers zero, one, the smallest primes, the largest 16-bit
// prime, perfect squares, powers of two, the candidate with the most divisors
// and alternating bit patterns. A random set follows. It mixes small numbers,
// squares and their neighbors, and numbers from the whole range.
// The sender and the receiver both pause at random between beats, with quiet
// runs of back-to-back beats. Once, the receiver holds off for a long stretch
// while candidates keep coming, so the block stalls its input.
// ----------------------------------------------------------------------------
module trial_division_prime_test_tb;

	// All 120 items at the slowest, with the longest pauses and the long
	// hold-off, stay well inside this bound.
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER = 30;
	localparam int RANDOM_ITEMS = 100;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic                         is_prime;
		logic [tdpt_pkg::COUNT_W-1:0] count;
	} verdict_t;

	logic clk;
	logic arst_n;

	tdpt_cand_if cand_ch ();
	tdpt_res_if  res_ch ();

	trial_division_prime_test dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cand   (cand_ch.sink),
		.res    (res_ch.source)
	);

	// Candidates that still wait to be sent, and verdicts that still wait to
	// come back, oldest first.
	logic [tdpt_pkg::CAND_W-1:0] pending_cands[$];
	verdict_t                    awaited_verdicts[$];

	// Handshakes seen at the last rising edge, read by the drivers at the
	// falling edge that follows.
	logic cand_took;
	logic res_took;

	int cands_taken;
	int results_seen;
	int items_total;
	int faults;
	int cycle_count;

	int send_wait;
	int send_quiet;
	int recv_wait;
	int recv_quiet;
	int hold_left;
	logic hold_used;

	verdict_t got;
	verdict_t want;

	// Counts the divisors of the candidate the way the block does: divisors
	// come in pairs up to the square root, and a perfect square adds its root
	// once. The count saturates at the top of the 7-bit field.
	function automatic verdict_t tally_divisors(input logic [tdpt_pkg::CAND_W-1:0] raw);
		longint unsigned n;
		longint unsigned d;
		int unsigned     hits;
		verdict_t        v;
		n = raw;
		if (tdpt_pkg::WIDTH < tdpt_pkg::CAND_W) begin
			n = n & ((64'd1 << tdpt_pkg::WIDTH) - 1);
		end
		hits = 0;
		for (d = 1; d * d <= n && hits < tdpt_pkg::COUNT_MAX; d++) begin
			if (n % d == 0) begin
				hits += (d * d == n) ? 1 : 2;
			end
		end
		if (hits > tdpt_pkg::COUNT_MAX) begin
			hits = tdpt_pkg::COUNT_MAX;
		end
		v.is_prime = (hits == tdpt_pkg::PRIME_DIVISORS);
		v.count = tdpt_pkg::COUNT_W'(hits);
		return v;
	endfunction

	// Draws the pause before the next beat. Now and then a quiet run starts,
	// during which beats follow each other with no pause at all.
	function automatic int idle_draw(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			quiet = $urandom_range(3, 12);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	// Clock: 8 ns period.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog. A hung block ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Monitor. Both channels are sampled at the rising edge. An accepted
	// candidate beat turns into an expected verdict at once; an accepted
	// result beat is checked against the oldest expected verdict.
	always @(posedge clk) begin
		cand_took <= arst_n && cand_ch.valid && cand_ch.ready;
		res_took <= arst_n && res_ch.valid && res_ch.ready;
		if (arst_n && cand_ch.valid && cand_ch.ready) begin
			awaited_verdicts.push_back(tally_divisors(cand_ch.candidate));
			cands_taken++;
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			results_seen++;
			got.is_prime = res_ch.is_prime;
			got.count = res_ch.divisor_count;
			if (awaited_verdicts.size() == 0) begin
				faults++;
				if (faults <= REPORT_MAX) begin
					$display("unexpected result beat: is_prime=%0d divisor_count=%0d",
						got.is_prime, got.count);
				end
			end else begin
				want = awaited_verdicts.pop_front();
				if (got.is_prime !== want.is_prime || got.count !== want.count) begin
					faults++;
					if (faults <= REPORT_MAX) begin
						$display("result mismatch: is_prime %0d, expected %0d; %s%0d, expected %0d",
							got.is_prime, want.is_prime, "divisor_count ",
							got.count, want.count);
					end
				end
			end
		end
	end

	// Sender. Right after a beat is taken it draws the pause before the next
	// one; a pause of zero puts the next candidate up on the same falling edge,
	// so valid stays high across back-to-back beats.
	logic offer;
	always @(negedge clk) begin
		if (!arst_n) begin
			cand_ch.valid <= 1'b0;
			send_wait = idle_draw(send_quiet);
		end else begin
			offer = cand_ch.valid;
			if (cand_took) begin
				offer = 1'b0;
				send_wait = idle_draw(send_quiet);
			end
			if (!offer) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (pending_cands.size() != 0) begin
					offer = 1'b1;
					cand_ch.candidate <= pending_cands.pop_front();
				end
			end
			cand_ch.valid <= offer;
		end
	end

	// Long hold-off. Once enough candidates have gone in, the receiver is kept
	// from taking results for a long stretch. The sender is not told, so it
	// keeps a candidate up while the block sits on an unread result.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_used && cands_taken >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end
	end

	// Receiver. After each result beat it draws how long to stay away before
	// it takes the next one.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_took) begin
				recv_wait = idle_draw(recv_quiet);
			end else if (recv_wait > 0) begin
				recv_wait--;
			end
			res_ch.ready <= (recv_wait == 0) && (hold_left == 0);
		end
	end

	// Stimulus and end of run.
	int root;
	initial begin
		cand_ch.valid = 1'b0;
		cand_ch.candidate = '0;
		res_ch.ready = 1'b0;
		arst_n = 1'b0;
		cand_took = 1'b0;
		res_took = 1'b0;
		cands_taken = 0;
		results_seen = 0;
		faults = 0;
		cycle_count = 0;
		send_wait = 0;
		send_quiet = 0;
		recv_wait = 0;
		recv_quiet = 0;
		hold_left = 0;
		hold_used = 1'b0;

		// Zero has no divisors in range and one has only itself; neither is
		// prime. Then the smallest primes and composites.
		pending_cands.push_back(16'd0);
		pending_cands.push_back(16'd1);
		pending_cands.push_back(16'd2);
		pending_cands.push_back(16'd3);
		pending_cands.push_back(16'd4);
		pending_cands.push_back(16'd9);
		pending_cands.push_back(16'd49);
		pending_cands.push_back(16'd97);
		pending_cands.push_back(16'd100);
		// Top of the range, and the largest prime below it.
		pending_cands.push_back(16'hFFFF);
		pending_cands.push_back(16'd65521);
		// Squares: the largest one, and the square of a prime.
		pending_cands.push_back(16'd65025);
		pending_cands.push_back(16'd63001);
		// Powers of two, including the top bit alone.
		pending_cands.push_back(16'd1024);
		pending_cands.push_back(16'h8000);
		// The most divisors any 16-bit number has (120), and 45360 with 100.
		pending_cands.push_back(16'd55440);
		pending_cands.push_back(16'd45360);
		// Alternating bit patterns, and then 65519.
		pending_cands.push_back(16'h5555);
		pending_cands.push_back(16'hAAAA);
		pending_cands.push_back(16'd65519);

		// Random part. Small numbers give many primes cheaply; squares and
		// their neighbors hit the single-root case; the full range reaches
		// every bit and the slowest items.
		repeat (RANDOM_ITEMS) begin
			case ($urandom_range(0, 3))
				0: pending_cands.push_back(tdpt_pkg::CAND_W'($urandom_range(0, 255)));
				1: begin
					root = $urandom_range(0, 255);
					pending_cands.push_back(
						tdpt_pkg::CAND_W'(root * root + $urandom_range(0, 2) - 1));
				end
				default: pending_cands.push_back(tdpt_pkg::CAND_W'($urandom_range(0, 65535)));
			endcase
		end
		items_total = pending_cands.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Every candidate has come back as a result beat. Polled at the falling
		// edge, when the rising-edge bookkeeping has settled.
		@(negedge clk);
		while (results_seen < items_total) begin
			@(negedge clk);
		end
		// Keep running to catch any stray result beat.
		repeat (50) @(posedge clk);

		if (faults == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
